>>> rtl/pbe_pkg.sv
// Shared constants, types and state codes of the PackBits pixel encoder.
package pbe_pkg;

  localparam int MAX_RUN = 32;
  localparam int CNT_W   = $clog2(MAX_RUN + 1);
  localparam int ADDR_W  = $clog2(MAX_RUN);
  localparam int BYTE_W  = 8;
  localparam int EL_W    = 3 * BYTE_W;
  localparam int HDR_W   = 8;
  localparam int IN_W    = EL_W;
  localparam int OUT_W   = HDR_W + EL_W;
  localparam int USER_W  = 2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [EL_W-1:0]   el_t;
  typedef logic [HDR_W-1:0]  hdr_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    el_t   wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } lit_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FINAL,
    ST_LIT_HDR,
    ST_LIT_ELEM,
    ST_REP_HDR,
    ST_REP_ELEM
  } state_e;

endpackage

>>> rtl/packbits_pixel_encoder_unit.sv
// Top level of the PackBits pixel encoder with its run sequencer.
//
// Channel  Direction  Handshake                      Content
// s_axis   in         s_axis_tvalid/s_axis_tready    one pixel element, tlast ends the image
// m_axis   out        m_axis_tvalid/m_axis_tready    one header or element byte group
// cfg      in         cfg_we_i                       gray_mode register
//
// An item that closes no run leaves the sequencer idle, and the next one may follow at once.
// An item that closes runs holds the input until all its results are sent, and a final
// element also passes ST_FINAL, which flushes the pending element; the output register and
// the single read port of the literal store give one result per cycle while not stalled.
// Reset clears all control state; the literal store needs no clearing pass.
// A stalled output holds the sequencer in place.
module packbits_pixel_encoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // red_or_gray [7:0], green [15:8], blue [23:16]
  input  logic [pbe_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // header_value [7:0], out_red_or_gray [15:8], out_green [23:16], out_blue [31:24]
  output logic [pbe_pkg::OUT_W-1:0]  m_axis_tdata,
  // is_header [0], stream_end [1]
  output logic [pbe_pkg::USER_W-1:0] m_axis_tuser,
  output logic                        m_axis_tlast
);
  import pbe_pkg::*;

  state_e   state_q, state_d;
  logic     gray_mode_q, gray_mode_d;
  cnt_t     lit_cnt_q, lit_cnt_d;
  el_t      pend_q, pend_d;
  logic     pend_valid_q, pend_valid_d;
  cnt_t     rep_cnt_q, rep_cnt_d;
  logic     rep_pend_q, rep_pend_d;
  el_t      rep_el_q, rep_el_d;
  cnt_t     rep_n_q, rep_n_d;
  cnt_t     flush_n_q, flush_n_d;
  logic     fin_pend_q, fin_pend_d;
  logic     fin_item_q, fin_item_d;
  addr_t    idx_q, idx_d;
  logic     out_valid_q, out_valid_d;
  logic     out_is_hdr_q, out_is_hdr_d;
  hdr_t     out_hdr_q, out_hdr_d;
  el_t      out_el_q, out_el_d;
  logic     out_last_q, out_last_d;
  logic     out_end_q, out_end_d;

  lit_req_t lit_req;
  el_t      rd_data;

  logic     in_fire;
  logic     out_free;
  el_t      in_el;
  logic     is_eq;
  cnt_t     rc_inc;
  logic     rep_full;
  logic     push;
  logic     push_full;
  logic     acc_flush;
  logic     acc_rep;
  logic     acc_fin;
  logic     pv_post;
  cnt_t     lit_post;
  logic     fin_rep;
  cnt_t     idx_nxt;
  logic     lit_more;

  function automatic cnt_t rc_dummy_sum(input cnt_t c);
    return c + cnt_t'(1);
  endfunction

  pbe_lit_store u_lit_store (
    .clk_i     (clk_i),
    .req_i     (lit_req),
    .rd_data_o (rd_data)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign in_el = gray_mode_q ? {s_axis_tdata[BYTE_W-1:0], {(2 * BYTE_W){1'b0}}}
                             : {s_axis_tdata[BYTE_W-1:0], s_axis_tdata[2*BYTE_W-1:BYTE_W],
                                s_axis_tdata[3*BYTE_W-1:2*BYTE_W]};

  assign is_eq     = pend_valid_q && (in_el == pend_q);
  assign rc_inc    = rep_cnt_q + cnt_t'(1);
  assign rep_full  = rc_inc >= cnt_t'(MAX_RUN);
  assign push      = pend_valid_q && !is_eq && (rep_cnt_q < cnt_t'(2));
  assign push_full = push && (rc_dummy_sum(lit_cnt_q) == cnt_t'(MAX_RUN));
  assign acc_flush = (is_eq && (rep_cnt_q == cnt_t'(1)) && (lit_cnt_q != '0)) || push_full;
  assign acc_rep   = (is_eq && rep_full) || (pend_valid_q && !is_eq && !push);
  assign pv_post   = !(is_eq && rep_full);
  assign lit_post  = acc_flush ? '0 : (push ? rc_dummy_sum(lit_cnt_q) : lit_cnt_q);
  assign acc_fin   = s_axis_tlast && (pv_post || (lit_post != '0));

  assign fin_rep  = pend_valid_q && (rep_cnt_q >= cnt_t'(2));
  assign idx_nxt  = cnt_t'(idx_q) + cnt_t'(1);
  assign lit_more = idx_nxt < flush_n_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (acc_flush) begin
            state_d = ST_LIT_HDR;
          end else if (acc_rep) begin
            state_d = ST_REP_HDR;
          end else if (acc_fin) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        state_d = fin_rep ? ST_REP_HDR : ST_LIT_HDR;
      end
      ST_LIT_HDR: begin
        if (out_free) begin
          state_d = ST_LIT_ELEM;
        end
      end
      ST_LIT_ELEM: begin
        if (out_free && !lit_more) begin
          if (rep_pend_q) begin
            state_d = ST_REP_HDR;
          end else if (fin_pend_q) begin
            state_d = ST_FINAL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REP_HDR: begin
        if (out_free) begin
          state_d = ST_REP_ELEM;
        end
      end
      ST_REP_ELEM: begin
        if (out_free) begin
          state_d = fin_pend_q ? ST_FINAL : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    gray_mode_d  = gray_mode_q;
    lit_cnt_d    = lit_cnt_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    rep_cnt_d    = rep_cnt_q;
    rep_pend_d   = rep_pend_q;
    rep_el_d     = rep_el_q;
    rep_n_d      = rep_n_q;
    flush_n_d    = flush_n_q;
    fin_pend_d   = fin_pend_q;
    fin_item_d   = fin_item_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_is_hdr_d = out_is_hdr_q;
    out_hdr_d    = out_hdr_q;
    out_el_d     = out_el_q;
    out_last_d   = out_last_q;
    out_end_d    = out_end_q;
    lit_req      = '0;

    if (cfg_we_i) begin
      gray_mode_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (push) begin
            lit_req.wr_en   = 1'b1;
            lit_req.wr_addr = lit_cnt_q[ADDR_W-1:0];
            lit_req.wr_data = pend_q;
          end
          lit_cnt_d    = lit_post;
          flush_n_d    = push_full ? cnt_t'(MAX_RUN) : lit_cnt_q;
          rep_pend_d   = acc_rep;
          rep_el_d     = pend_q;
          rep_n_d      = is_eq ? rc_inc : rep_cnt_q;
          pend_valid_d = pv_post;
          if (!is_eq) begin
            pend_d    = in_el;
            rep_cnt_d = cnt_t'(1);
          end else begin
            rep_cnt_d = rep_full ? '0 : rc_inc;
          end
          fin_pend_d = acc_fin;
          fin_item_d = s_axis_tlast;
        end
      end
      ST_FINAL: begin
        if (fin_rep) begin
          rep_pend_d = 1'b1;
          rep_el_d   = pend_q;
          rep_n_d    = rep_cnt_q;
        end else if (pend_valid_q) begin
          lit_req.wr_en   = 1'b1;
          lit_req.wr_addr = lit_cnt_q[ADDR_W-1:0];
          lit_req.wr_data = pend_q;
          flush_n_d       = rc_dummy_sum(lit_cnt_q);
        end else begin
          flush_n_d = lit_cnt_q;
        end
        lit_cnt_d    = '0;
        pend_valid_d = 1'b0;
        rep_cnt_d    = '0;
        fin_pend_d   = 1'b0;
      end
      ST_LIT_HDR: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_is_hdr_d    = 1'b1;
          out_hdr_d       = HDR_W'(flush_n_q) - HDR_W'(1);
          out_el_d        = '0;
          out_last_d      = 1'b0;
          out_end_d       = 1'b0;
          lit_req.rd_en   = 1'b1;
          lit_req.rd_addr = '0;
          idx_d           = '0;
        end
      end
      ST_LIT_ELEM: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_is_hdr_d = 1'b0;
          out_hdr_d    = '0;
          out_el_d     = rd_data;
          out_last_d   = !lit_more && !rep_pend_q && !fin_pend_q;
          out_end_d    = !lit_more && !rep_pend_q && !fin_pend_q && fin_item_q;
          if (lit_more) begin
            lit_req.rd_en   = 1'b1;
            lit_req.rd_addr = idx_nxt[ADDR_W-1:0];
            idx_d           = idx_nxt[ADDR_W-1:0];
          end
        end
      end
      ST_REP_HDR: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_is_hdr_d = 1'b1;
          out_hdr_d    = HDR_W'(1) - HDR_W'(rep_n_q);
          out_el_d     = '0;
          out_last_d   = 1'b0;
          out_end_d    = 1'b0;
        end
      end
      ST_REP_ELEM: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_is_hdr_d = 1'b0;
          out_hdr_d    = '0;
          out_el_d     = rep_el_q;
          out_last_d   = !fin_pend_q;
          out_end_d    = !fin_pend_q && fin_item_q;
          rep_pend_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gray_mode_q  <= 1'b0;
      lit_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      rep_cnt_q    <= '0;
      rep_pend_q   <= 1'b0;
      fin_pend_q   <= 1'b0;
      fin_item_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      gray_mode_q  <= gray_mode_d;
      lit_cnt_q    <= lit_cnt_d;
      pend_valid_q <= pend_valid_d;
      rep_cnt_q    <= rep_cnt_d;
      rep_pend_q   <= rep_pend_d;
      fin_pend_q   <= fin_pend_d;
      fin_item_q   <= fin_item_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q       <= pend_d;
    rep_el_q     <= rep_el_d;
    rep_n_q      <= rep_n_d;
    flush_n_q    <= flush_n_d;
    idx_q        <= idx_d;
    out_is_hdr_q <= out_is_hdr_d;
    out_hdr_q    <= out_hdr_d;
    out_el_q     <= out_el_d;
    out_last_q   <= out_last_d;
    out_end_q    <= out_end_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_el_q[BYTE_W-1:0], out_el_q[2*BYTE_W-1:BYTE_W],
                          out_el_q[3*BYTE_W-1:2*BYTE_W], out_hdr_q};
  assign m_axis_tuser  = {out_end_q, out_is_hdr_q};
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/pbe_lit_store.sv
// Literal run store: one write port and one registered read port.
module pbe_lit_store (
  input  logic              clk_i,
  input  pbe_pkg::lit_req_t req_i,
  output pbe_pkg::el_t      rd_data_o
);
  import pbe_pkg::*;

  el_t mem [MAX_RUN];
  el_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> bench/packbits_pixel_encoder_unit_tb.sv
// Self-checking testbench for the PackBits pixel encoder, driven with directed and random run streams.
`timescale 1ns / 1ps

module packbits_pixel_encoder_unit_tb;
  import pbe_pkg::*;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  is_header;
    hdr_t  header_value;
    byte_t red_or_gray;
    byte_t green;
    byte_t blue;
    logic  last_of_burst;
    logic  stream_end;
  } pixel_result_t;

  class packbits_scoreboard;
    el_t           lit_store[MAX_RUN];
    int            lit_count = 0;
    int            rep_count = 0;
    el_t           pend_el = '0;
    bit            pend_valid = 1'b0;
    bit            gray = 1'b0;
    pixel_result_t expected_q[$];
    pixel_result_t burst_q[$];

    function void add(bit hdr, int hval, el_t el);
      pixel_result_t res;
      res = '0;
      res.is_header    = hdr;
      res.header_value = hval[7:0];
      res.red_or_gray  = el[23:16];
      res.green        = el[15:8];
      res.blue         = el[7:0];
      burst_q.insert(burst_q.size(), res);
    endfunction

    function void flush_literal();
      if (lit_count == 0) return;
      add(1'b1, lit_count - 1, '0);
      for (int k = 0; k < lit_count; k++) add(1'b0, 0, lit_store[k]);
      lit_count = 0;
    endfunction

    function void emit_repeat();
      add(1'b1, -(rep_count - 1), '0);
      add(1'b0, 0, pend_el);
      pend_valid = 1'b0;
      rep_count  = 0;
    endfunction

    function void push_literal();
      if (lit_count < MAX_RUN) begin
        lit_store[lit_count] = pend_el;
        lit_count++;
      end
      if (lit_count >= MAX_RUN) flush_literal();
    endfunction

    function void note_pixel(byte_t r, byte_t g, byte_t b, bit fin);
      el_t           el;
      pixel_result_t tail;
      el = gray ? {r, 16'h0000} : {r, g, b};
      burst_q.delete();
      if (!pend_valid) begin
        pend_el    = el;
        pend_valid = 1'b1;
        rep_count  = 1;
      end else if (el == pend_el) begin
        if (rep_count == 1) flush_literal();
        rep_count++;
        if (rep_count >= MAX_RUN) emit_repeat();
      end else begin
        if (rep_count >= 2) emit_repeat();
        else push_literal();
        pend_el    = el;
        pend_valid = 1'b1;
        rep_count  = 1;
      end
      if (fin) begin
        if (pend_valid) begin
          if (rep_count >= 2) emit_repeat();
          else push_literal();
        end
        flush_literal();
        pend_valid = 1'b0;
        rep_count  = 0;
      end
      if (burst_q.size() > 0) begin
        tail = burst_q.pop_back();
        tail.last_of_burst = 1'b1;
        tail.stream_end    = fin;
        burst_q.insert(burst_q.size(), tail);
      end
      foreach (burst_q[k]) expected_q.insert(expected_q.size(), burst_q[k]);
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function string show(pixel_result_t r);
      return $sformatf("hdr=%0b val=%02h rgb=%02h_%02h_%02h tlast=%0b end=%0b",
                       r.is_header, r.header_value, r.red_or_gray, r.green, r.blue,
                       r.last_of_burst, r.stream_end);
    endfunction

    function string check_result(pixel_result_t got);
      pixel_result_t want;
      if (expected_q.size() == 0) return {"result with nothing expected: ", show(got)};
      want = expected_q.pop_front();
      if (got.is_header !== want.is_header || got.header_value !== want.header_value ||
          got.red_or_gray !== want.red_or_gray || got.green !== want.green ||
          got.blue !== want.blue || got.last_of_burst !== want.last_of_burst ||
          got.stream_end !== want.stream_end)
        return {"got ", show(got), ", want ", show(want)};
      return "";
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 8;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic [USER_W-1:0] m_axis_tuser;
  logic              m_axis_tlast;

  packbits_scoreboard sb;
  int    mismatch_count = 0;
  int    src_rate = 3;
  int    sink_rate = 3;
  int    sink_hold = 0;
  int    sent_count = 0;
  int    rate_choice[4] = '{0, 2, 4, 10};
  byte_t prev_r = '0;
  byte_t prev_g = '0;
  byte_t prev_b = '0;

  packbits_pixel_encoder_unit dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("[packbits_pixel_encoder_unit] ERROR");
    $finish;
  end

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : sink_ctrl
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (sink_rate != 0 && $urandom_range(1, sink_rate) == 1) begin
      m_axis_tready <= 1'b0;
      sink_hold <= $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    pixel_result_t got;
    string         msg;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.is_header     = m_axis_tuser[0];
        got.stream_end    = m_axis_tuser[1];
        got.header_value  = m_axis_tdata[7:0];
        got.red_or_gray   = m_axis_tdata[15:8];
        got.green         = m_axis_tdata[23:16];
        got.blue          = m_axis_tdata[31:24];
        got.last_of_burst = m_axis_tlast;
        msg = sb.check_result(got);
        if (msg != "") report(msg);
      end
      if (s_axis_tvalid && s_axis_tready)
        sb.note_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                      s_axis_tlast);
    end
  end

  task automatic offer_pixel(byte_t r, byte_t g, byte_t b, bit fin);
    if (src_rate != 0 && $urandom_range(1, src_rate) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    prev_r = r;
    prev_g = g;
    prev_b = b;
    sent_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gray(bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.gray = v;
  endtask

  task automatic run_segment();
    int    kind;
    int    len;
    bit    end_img;
    byte_t r;
    byte_t g;
    byte_t b;
    kind    = $urandom_range(0, 9);
    end_img = ($urandom_range(0, 4) == 0);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case (kind)
      0, 1, 2, 3: begin
        case ($urandom_range(0, 3))
          0: len = $urandom_range(2, 6);
          1: len = $urandom_range(MAX_RUN - 1, MAX_RUN + 1);
          2: len = $urandom_range(1, 2 * MAX_RUN + 2);
          default: len = $urandom_range(2, 12);
        endcase
        for (int k = 0; k < len; k++) begin
          if (sb.gray) begin
            g = 8'($urandom);
            b = 8'($urandom);
          end
          offer_pixel(r, g, b, end_img && k == len - 1);
        end
      end
      4, 5, 6: begin
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(MAX_RUN - 1, MAX_RUN + 2)
                                          : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
          if (sb.gray ? r == prev_r : {r, g, b} == {prev_r, prev_g, prev_b}) r = r + 8'd1;
          offer_pixel(r, g, b, end_img && k == len - 1);
        end
      end
      7: begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          offer_pixel(r, g, b, end_img && k == len - 1);
        end
      end
      default: begin
        len = (kind == 8) ? $urandom_range(1, 3) : 1;
        for (int k = 0; k < len; k++) begin
          offer_pixel(8'($urandom), 8'($urandom), 8'($urandom), k == len - 1);
        end
      end
    endcase
  endtask

  initial begin : stimulus
    int phase;
    sb = new;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_gray(1'b0);

    offer_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    offer_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    offer_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    offer_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    offer_pixel(8'h12, 8'h34, 8'h57, 1'b0);
    offer_pixel(8'h12, 8'h35, 8'h56, 1'b0);
    offer_pixel(8'h13, 8'h34, 8'h56, 1'b1);
    offer_pixel(8'h80, 8'h00, 8'hFF, 1'b0);
    offer_pixel(8'h80, 8'h00, 8'hFF, 1'b0);
    offer_pixel(8'h01, 8'h02, 8'h03, 1'b0);
    offer_pixel(8'h01, 8'h02, 8'h03, 1'b0);
    offer_pixel(8'h7F, 8'h7F, 8'h7F, 1'b1);
    offer_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    offer_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    offer_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    offer_pixel(8'h00, 8'h11, 8'h22, 1'b1);
    drain();
    write_gray(1'b1);
    offer_pixel(8'h55, 8'h12, 8'h34, 1'b0);
    offer_pixel(8'h55, 8'hAB, 8'hCD, 1'b0);
    offer_pixel(8'hFE, 8'h01, 8'h01, 1'b0);
    offer_pixel(8'h00, 8'hFF, 8'hFF, 1'b1);
    // A gray run is still pending when the mode switches back to color.
    offer_pixel(8'h30, 8'h40, 8'h50, 1'b0);
    offer_pixel(8'h30, 8'h99, 8'h99, 1'b0);
    drain();
    write_gray(1'b0);
    offer_pixel(8'h30, 8'h40, 8'h50, 1'b0);
    offer_pixel(8'h30, 8'h40, 8'h50, 1'b1);

    sent_count = 0;
    phase = 0;
    while (sent_count < 320) begin
      drain();
      write_gray(phase % 4 == 0 ? 1'b0 : phase % 4 == 1 ? 1'b1 : 1'($urandom));
      if (sent_count >= 260) begin
        src_rate  = 0;
        sink_rate = 0;
      end else begin
        src_rate  = rate_choice[$urandom_range(0, 3)];
        sink_rate = rate_choice[$urandom_range(0, 3)];
      end
      repeat ($urandom_range(2, 6)) run_segment();
      phase++;
    end
    offer_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    drain();

    if (mismatch_count == 0) begin
      $display("[packbits_pixel_encoder_unit] OK");
    end else begin
      $display("[packbits_pixel_encoder_unit] ERROR");
    end
    $finish;
  end

endmodule
